// File: hw/rtl/escape_sequence_guard_detector_core_defines.svh
// Assertion helpers shared by the RTL.
`ifndef ESCAPE_SEQUENCE_GUARD_DETECTOR_CORE_DEFINES_SVH
`define ESCAPE_SEQUENCE_GUARD_DETECTOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define ESGD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define ESGD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/esgd_pkg.sv
package esgd_pkg;

    localparam int GAP_COUNTER_BITS_DEF = 16;
    localparam int GAP_TICKS_W          = 16;
    localparam int CFG_ADDR_W           = 3;
    localparam int CFG_DATA_W           = 16;
    localparam int QUEUE_DEPTH          = 2;
    localparam int S_TDATA_W            = 8;
    localparam int M_TDATA_W            = 16;

    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_DETECT_ENABLE    = 3'd0,
        CFG_GATEWAY_MODE     = 3'd1,
        CFG_CODE_BYTE_FIRST  = 3'd2,
        CFG_CODE_BYTE_SECOND = 3'd3,
        CFG_CODE_BYTE_THIRD  = 3'd4,
        CFG_GAP_TICKS        = 3'd5
    } t_cfg_idx;

    // One decoded item: held bytes to replay, then a status word.
    typedef struct packed {
        logic [1:0]      nrep;
        logic [2:0][7:0] bytes;
        logic [1:0]      mcount;
        logic            sw_ready;
    } t_job;

endpackage

// File: hw/rtl/escape_sequence_guard_detector_core.sv
// Escape code detector with guard gaps. Slave words carry either a received byte (tuser 0) or a
// timer tick (tuser 1); each is classified in the cycle it is accepted and queued as one job in a
// two-entry queue. The output side plays a job out as up to three replayed bytes (tuser 1) and
// then one status word (tlast 1), one word per cycle while the master port is ready. Input is
// taken every cycle while the queue has room. An item that replays k bytes yields k+1 words on
// the master port, so the output port, not the input, sets the sustained item rate. An accepted
// item is registered in the queue and then in the output stage before its first word is valid
// on the master port. Configuration registers are written through the plain write port; the
// user must write them only while no item is in flight, as the block does not enforce this.
module escape_sequence_guard_detector_core #(
    parameter int GAP_COUNTER_BITS = esgd_pkg::GAP_COUNTER_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [esgd_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [esgd_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [esgd_pkg::S_TDATA_W-1:0]  i_s_axis_tdata,  // [7:0] rx_byte
    input  logic                            i_s_axis_tuser,  // [0] req_type
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [esgd_pkg::M_TDATA_W-1:0]  o_m_axis_tdata,  // [7:0] replay_byte, [9:8] match_count,
                                                             // [10] switch_ready, [15:11] zero
    output logic                            o_m_axis_tuser,  // [0] replay_valid
    output logic                            o_m_axis_tlast
);
    import esgd_pkg::*;

    logic q_full;
    logic q_push;
    logic q_valid;
    logic q_pop;
    t_job front_job;
    t_job q_job;

    esgd_front #(
        .GAP_COUNTER_BITS(GAP_COUNTER_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_wdata(i_cfg_wdata),
        .i_valid    (i_s_axis_tvalid),
        .i_req_type (i_s_axis_tuser),
        .i_rx_byte  (i_s_axis_tdata[7:0]),
        .o_ready    (o_s_axis_tready),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_job      (front_job)
    );

    esgd_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_job  (front_job),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_valid(q_valid),
        .o_job  (q_job)
    );

    esgd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_valid(q_valid),
        .i_job    (q_job),
        .o_pop    (q_pop),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_data   (o_m_axis_tdata),
        .o_user   (o_m_axis_tuser),
        .o_last   (o_m_axis_tlast)
    );

endmodule

// File: hw/rtl/esgd_front.sv
module esgd_front #(
    parameter int GAP_COUNTER_BITS = esgd_pkg::GAP_COUNTER_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [esgd_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [esgd_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                            i_valid,
    input  logic                            i_req_type,
    input  logic [7:0]                      i_rx_byte,
    output logic                            o_ready,
    input  logic                            i_q_full,
    output logic                            o_push,
    output esgd_pkg::t_job                  o_job
);
    import esgd_pkg::*;

    localparam int CMP_W = (GAP_COUNTER_BITS > GAP_TICKS_W) ? GAP_COUNTER_BITS : GAP_TICKS_W;

    logic                        r_en;
    logic                        r_gw;
    logic [7:0]                  r_code0;
    logic [7:0]                  r_code1;
    logic [7:0]                  r_code2;
    logic [GAP_TICKS_W-1:0]      r_gap;

    logic [1:0]                  r_mi,    n_mi;
    logic [2:0][7:0]             r_held,  n_held;
    logic [GAP_COUNTER_BITS-1:0] r_gc,    n_gc;
    logic                        r_timer, n_timer;

    logic                        accept;
    logic                        active;
    logic                        fail;
    logic [GAP_COUNTER_BITS-1:0] gc_inc;
    logic [CMP_W-1:0]            gc_ext;
    logic [CMP_W-1:0]            gc_inc_ext;
    logic [CMP_W-1:0]            gap_ext;
    logic [7:0]                  code_sel;
    t_job                        job;

    assign o_ready    = !i_q_full;
    assign accept     = i_valid && o_ready;
    assign active     = r_en && r_gw;
    assign gc_inc     = (r_gc == '1) ? r_gc : r_gc + 1'b1;
    assign gc_ext     = CMP_W'(r_gc);
    assign gc_inc_ext = CMP_W'(gc_inc);
    assign gap_ext    = CMP_W'(r_gap);
    assign code_sel   = (r_mi == 2'd1) ? r_code1 : r_code2;

    always_comb begin
        n_mi    = r_mi;
        n_held  = r_held;
        n_gc    = r_gc;
        n_timer = r_timer;
        fail    = 1'b0;
        job     = '0;
        if (accept) begin
            if (i_req_type == REQ_TICK) begin
                n_gc = gc_inc;
                job.sw_ready = active && (r_mi == 2'd3) && r_timer && (gc_inc_ext >= gap_ext);
            end else if (active) begin
                unique case (r_mi)
                    2'd0: begin
                        if (i_rx_byte == r_code0 && gc_ext >= gap_ext) begin
                            n_held[0] = i_rx_byte;
                            n_mi      = 2'd1;
                            n_timer   = 1'b1;
                        end
                    end
                    2'd1, 2'd2: begin
                        if (i_rx_byte == code_sel && gc_ext <= gap_ext) begin
                            n_held[r_mi] = i_rx_byte;
                            n_mi         = r_mi + 2'd1;
                        end else begin
                            fail = 1'b1;
                        end
                    end
                    default: begin
                        if (gc_ext < gap_ext) fail = 1'b1;
                    end
                endcase
                if (fail) begin
                    job.nrep  = r_mi;
                    job.bytes = r_held;
                    for (int i = 0; i < 3; i++) begin
                        if (2'(i) < r_mi) n_held[i] = 8'd0;
                    end
                    n_timer = 1'b0;
                    n_mi    = 2'd0;
                end
                n_gc = '0;
            end
        end
        job.mcount = n_mi;
    end

    assign o_push = accept;
    assign o_job  = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en    <= 1'b0;
            r_gw    <= 1'b1;
            r_code0 <= 8'd43;
            r_code1 <= 8'd43;
            r_code2 <= 8'd43;
            r_gap   <= GAP_TICKS_W'(500);
            r_mi    <= 2'd0;
            r_held  <= '0;
            r_gc    <= '0;
            r_timer <= 1'b0;
        end else begin
            r_mi    <= n_mi;
            r_held  <= n_held;
            r_gc    <= n_gc;
            r_timer <= n_timer;
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_addr))
                    CFG_DETECT_ENABLE:    r_en    <= i_cfg_wdata[0];
                    CFG_GATEWAY_MODE:     r_gw    <= i_cfg_wdata[0];
                    CFG_CODE_BYTE_FIRST:  r_code0 <= i_cfg_wdata[7:0];
                    CFG_CODE_BYTE_SECOND: r_code1 <= i_cfg_wdata[7:0];
                    CFG_CODE_BYTE_THIRD:  r_code2 <= i_cfg_wdata[7:0];
                    CFG_GAP_TICKS:        r_gap   <= i_cfg_wdata[GAP_TICKS_W-1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

// File: hw/rtl/esgd_queue.sv
module esgd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  esgd_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output esgd_pkg::t_job o_job
);
    import esgd_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    t_job             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_cnt;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_cnt == CNT_FULL);
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wptr] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) r_wptr <= (r_wptr == PTR_LAST) ? '0 : r_wptr + 1'b1;
            if (do_pop)  r_rptr <= (r_rptr == PTR_LAST) ? '0 : r_rptr + 1'b1;
            if (do_push && !do_pop)      r_cnt <= r_cnt + 1'b1;
            else if (do_pop && !do_push) r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule

// File: hw/rtl/esgd_back.sv
`include "escape_sequence_guard_detector_core_defines.svh"

module esgd_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_q_valid,
    input  esgd_pkg::t_job                 i_job,
    output logic                           o_pop,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [esgd_pkg::M_TDATA_W-1:0] o_data,
    output logic                           o_user,
    output logic                           o_last
);
    import esgd_pkg::*;

    logic       r_busy;
    t_job       r_job;
    logic [1:0] r_idx;

    logic       last;
    logic       done;
    logic       load;
    logic [7:0] byte_out;

    assign last     = (r_idx == r_job.nrep);
    assign done     = r_busy && i_ready && last;
    assign load     = i_q_valid && (!r_busy || done);
    assign o_pop    = load;
    assign byte_out = last ? 8'd0 : r_job.bytes[r_idx];

    assign o_valid = r_busy;
    assign o_user  = !last;
    assign o_last  = last;
    assign o_data  = {(M_TDATA_W - 11)'(0), r_job.sw_ready && last, r_job.mcount, byte_out};

    always_ff @(posedge i_clk) begin
        if (load) r_job <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else begin
            if (load) begin
                r_busy <= 1'b1;
                r_idx  <= 2'd0;
            end else if (done) begin
                r_busy <= 1'b0;
            end else if (r_busy && i_ready) begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    `ESGD_ASSERT_IMP(a_idx_in_range, i_clk, i_rst_n, r_busy, r_idx <= r_job.nrep, "replay index past count")
    `ESGD_ASSERT_NXT(a_replay_advances, i_clk, i_rst_n, r_busy && i_ready && !last, r_busy && r_idx == $past(r_idx) + 2'd1, "replay did not advance")
    `ESGD_ASSERT_IMP(a_no_pop_mid_job, i_clk, i_rst_n, r_busy && !done, !o_pop, "job fetched before current one finished")
    `ESGD_ASSERT_IMP(a_replay_no_ready, i_clk, i_rst_n, r_busy && !last, !o_data[10], "switch ready on a replay word")

endmodule
